### hdl/slcan_pkg.sv
// Shared types, constants and the hex digit function of the SLCAN frame encoder.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package slcan_pkg;

   // Most data bytes that may be printed, and the number of data byte slots in a frame
   localparam logic [3:0] MAX_DATA_BYTES = 4'd8;
   localparam int         NUM_BYTES      = 8;

   // ASCII codes
   localparam logic [6:0] CHAR_EXT = 7'h54;   // 'T'
   localparam logic [6:0] CHAR_STD = 7'h74;   // 't'
   localparam logic [6:0] CHAR_CR  = 7'h0D;   // carriage return
   localparam logic [6:0] CHAR_NUL = 7'h00;

   // Identifier and timestamp digit counters start one below the digit count
   localparam logic [2:0] EXT_ID_TOP = 3'd7;
   localparam logic [2:0] STD_ID_TOP = 3'd2;
   localparam logic [2:0] STAMP_TOP  = 3'd3;

   // One classified frame as it travels through the queue
   typedef struct packed {
      logic                      extended;
      logic [28:0]               identifier;
      logic [3:0]                length_code;
      logic [3:0]                nbytes;
      logic [NUM_BYTES-1:0][7:0] data;
      logic [15:0]               stamp;
   } frame_type;

   // Queue fill status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Phases of the character sequencer
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEAD,
      PH_ID,
      PH_LEN,
      PH_DATA,
      PH_STAMP,
      PH_CR
   } phase_type;

   // Uppercase hex digit of one nibble
   function automatic logic [6:0] hex_char(input logic [3:0] nibble);
      logic [6:0] wide;
      wide = {3'b000, nibble};
      if (nibble < 4'd10) begin
         hex_char = 7'h30 + wide;
      end else begin
         hex_char = 7'h37 + wide;
      end
   endfunction

endpackage

`default_nettype wire

### hdl/slcan_frame_encoder_top.sv
// SLCAN frame encoder: one command beat in, one ASCII character beat per cycle out.
// A run is 6 to 31 characters; the command is stored in the queue, then loaded by the sequencer.
// Frames in the two-entry queue stream with no gap; a dry queue returns the sequencer to idle.
// The sequencer in the back end sets the rate of one character per cycle; the output cannot stall.
// Synchronous reset empties the queue, idles the sequencer and clears timestamp_enable.
// Depends on slcan_pkg, slcan_front, slcan_queue and slcan_back.
`default_nettype none

module slcan_frame_encoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_extended,
   input  wire logic [28:0] req_identifier,
   input  wire logic [3:0]  req_length_code,
   input  wire logic [7:0]  req_byte0,
   input  wire logic [7:0]  req_byte1,
   input  wire logic [7:0]  req_byte2,
   input  wire logic [7:0]  req_byte3,
   input  wire logic [7:0]  req_byte4,
   input  wire logic [7:0]  req_byte5,
   input  wire logic [7:0]  req_byte6,
   input  wire logic [7:0]  req_byte7,
   input  wire logic [15:0] req_stamp,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_timestamp_enable,
   output logic             rsp_strobe,
   output logic [6:0]       rsp_character,
   output logic             rsp_last
);

   slcan_pkg::queue_status_type status;
   slcan_pkg::frame_type        wr_frame;
   slcan_pkg::frame_type        rd_frame;
   logic                        push;
   logic                        pop;

   slcan_front u_front (
      .start           (start),
      .busy            (busy),
      .req_extended    (req_extended),
      .req_identifier  (req_identifier),
      .req_length_code (req_length_code),
      .req_byte0       (req_byte0),
      .req_byte1       (req_byte1),
      .req_byte2       (req_byte2),
      .req_byte3       (req_byte3),
      .req_byte4       (req_byte4),
      .req_byte5       (req_byte5),
      .req_byte6       (req_byte6),
      .req_byte7       (req_byte7),
      .req_stamp       (req_stamp),
      .status          (status),
      .push            (push),
      .frame           (wr_frame)
   );

   slcan_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_frame (wr_frame),
      .pop      (pop),
      .rd_frame (rd_frame),
      .status   (status)
   );

   slcan_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_timestamp_enable (csr_timestamp_enable),
      .status               (status),
      .rd_frame             (rd_frame),
      .pop                  (pop),
      .rsp_strobe           (rsp_strobe),
      .rsp_character        (rsp_character),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

### hdl/slcan_front.sv
// Front end: takes frames on the command port and classifies them for the queue.
// Depends on slcan_pkg.
`default_nettype none

module slcan_front (
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_extended,
   input  wire logic [28:0]                 req_identifier,
   input  wire logic [3:0]                  req_length_code,
   input  wire logic [7:0]                  req_byte0,
   input  wire logic [7:0]                  req_byte1,
   input  wire logic [7:0]                  req_byte2,
   input  wire logic [7:0]                  req_byte3,
   input  wire logic [7:0]                  req_byte4,
   input  wire logic [7:0]                  req_byte5,
   input  wire logic [7:0]                  req_byte6,
   input  wire logic [7:0]                  req_byte7,
   input  wire logic [15:0]                 req_stamp,
   input  wire slcan_pkg::queue_status_type status,
   output logic                             push,
   output slcan_pkg::frame_type             frame
);

   // Hold off new commands while the queue is full
   assign busy = status.full;
   assign push = start && !status.full;

   // Mask standard identifiers, clamp the byte count, gather the data
   always_comb begin
      frame.extended    = req_extended;
      frame.identifier  = req_extended ? req_identifier
                                       : {17'd0, req_identifier[11:0]};
      frame.length_code = req_length_code;
      frame.nbytes      = (req_length_code > slcan_pkg::MAX_DATA_BYTES)
                          ? slcan_pkg::MAX_DATA_BYTES : req_length_code;
      frame.data[0]     = req_byte0;
      frame.data[1]     = req_byte1;
      frame.data[2]     = req_byte2;
      frame.data[3]     = req_byte3;
      frame.data[4]     = req_byte4;
      frame.data[5]     = req_byte5;
      frame.data[6]     = req_byte6;
      frame.data[7]     = req_byte7;
      frame.stamp       = req_stamp;
   end

endmodule

`default_nettype wire

### hdl/slcan_queue.sv
// Two-entry frame queue between the front end and the character sequencer.
// Depends on slcan_pkg.
`default_nettype none

module slcan_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire slcan_pkg::frame_type wr_frame,
   input  wire logic                 pop,
   output slcan_pkg::frame_type      rd_frame,
   output slcan_pkg::queue_status_type status
);

   slcan_pkg::frame_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_frame     = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming frame
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_frame;
      end
   end

endmodule

`default_nettype wire

### hdl/slcan_back.sv
// Back end: character sequencer that spells one queued frame per run, plus the
// timestamp enable register. Depends on slcan_pkg.
`default_nettype none

module slcan_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_timestamp_enable,
   input  wire slcan_pkg::queue_status_type status,
   input  wire slcan_pkg::frame_type        rd_frame,
   output logic                             pop,
   output logic                             rsp_strobe,
   output logic [6:0]                       rsp_character,
   output logic                             rsp_last
);

   slcan_pkg::phase_type state_ff, state_in;
   slcan_pkg::frame_type work_ff;
   logic       ts_enable_ff;
   logic [2:0] cnt_ff,  cnt_in;
   logic [2:0] bidx_ff, bidx_in;
   logic       nib_ff,  nib_in;
   logic       load;
   logic       last_byte;
   logic [31:0] id_word;
   logic [7:0]  cur_byte;

   assign csr_ready = 1'b1;

   // Take the next frame when idle or on the closing character
   assign load = ((state_ff == slcan_pkg::PH_IDLE) || (state_ff == slcan_pkg::PH_CR))
                 && !status.empty;
   assign pop  = load;

   assign last_byte = (({1'b0, bidx_ff} + 4'd1) == work_ff.nbytes);
   assign id_word   = {3'b000, work_ff.identifier};
   assign cur_byte  = work_ff.data[bidx_ff];

   // Next phase
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slcan_pkg::PH_IDLE: begin
            if (load) state_in = slcan_pkg::PH_HEAD;
         end
         slcan_pkg::PH_HEAD: begin
            state_in = slcan_pkg::PH_ID;
         end
         slcan_pkg::PH_ID: begin
            if (cnt_ff == 3'd0) state_in = slcan_pkg::PH_LEN;
         end
         slcan_pkg::PH_LEN: begin
            if (work_ff.nbytes != 4'd0) begin
               state_in = slcan_pkg::PH_DATA;
            end else if (ts_enable_ff) begin
               state_in = slcan_pkg::PH_STAMP;
            end else begin
               state_in = slcan_pkg::PH_CR;
            end
         end
         slcan_pkg::PH_DATA: begin
            if (!nib_ff && last_byte) begin
               state_in = ts_enable_ff ? slcan_pkg::PH_STAMP : slcan_pkg::PH_CR;
            end
         end
         slcan_pkg::PH_STAMP: begin
            if (cnt_ff == 3'd0) state_in = slcan_pkg::PH_CR;
         end
         slcan_pkg::PH_CR: begin
            state_in = load ? slcan_pkg::PH_HEAD : slcan_pkg::PH_IDLE;
         end
         default: state_in = slcan_pkg::PH_IDLE;
      endcase
   end

   // Digit, byte and nibble counters
   always_comb begin
      cnt_in  = cnt_ff;
      bidx_in = bidx_ff;
      nib_in  = nib_ff;
      case (state_ff) inside
         slcan_pkg::PH_HEAD: begin
            cnt_in = work_ff.extended ? slcan_pkg::EXT_ID_TOP : slcan_pkg::STD_ID_TOP;
         end
         slcan_pkg::PH_ID, slcan_pkg::PH_STAMP: begin
            cnt_in = cnt_ff - 3'd1;
         end
         slcan_pkg::PH_LEN: begin
            cnt_in  = slcan_pkg::STAMP_TOP;
            bidx_in = 3'd0;
            nib_in  = 1'b1;
         end
         slcan_pkg::PH_DATA: begin
            if (nib_ff) begin
               nib_in = 1'b0;
            end else begin
               nib_in  = 1'b1;
               bidx_in = bidx_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Character for the current phase
   always_comb begin
      rsp_strobe    = 1'b1;
      rsp_last      = 1'b0;
      rsp_character = slcan_pkg::CHAR_NUL;
      unique case (state_ff)
         slcan_pkg::PH_IDLE: begin
            rsp_strobe = 1'b0;
         end
         slcan_pkg::PH_HEAD: begin
            rsp_character = work_ff.extended ? slcan_pkg::CHAR_EXT : slcan_pkg::CHAR_STD;
         end
         slcan_pkg::PH_ID: begin
            rsp_character = slcan_pkg::hex_char(id_word[{cnt_ff, 2'b00} +: 4]);
         end
         slcan_pkg::PH_LEN: begin
            rsp_character = slcan_pkg::hex_char(work_ff.length_code);
         end
         slcan_pkg::PH_DATA: begin
            rsp_character = slcan_pkg::hex_char(nib_ff ? cur_byte[7:4] : cur_byte[3:0]);
         end
         slcan_pkg::PH_STAMP: begin
            rsp_character = slcan_pkg::hex_char(work_ff.stamp[{cnt_ff[1:0], 2'b00} +: 4]);
         end
         slcan_pkg::PH_CR: begin
            rsp_character = slcan_pkg::CHAR_CR;
            rsp_last      = 1'b1;
         end
         default: begin
            rsp_strobe = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slcan_pkg::PH_IDLE;
         ts_enable_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            ts_enable_ff <= csr_timestamp_enable;
         end
      end
   end

   // Working frame and counters
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      bidx_ff <= bidx_in;
      nib_ff  <= nib_in;
      if (load) begin
         work_ff <= rd_frame;
      end
   end

endmodule

`default_nettype wire

### hdl/slcan_checker.sv
// Port-level checks on the character stream of the SLCAN frame encoder.
// Depends on slcan_pkg; bound to slcan_frame_encoder_top below.
`default_nettype none

module slcan_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_strobe,
   input wire logic [6:0] rsp_character,
   input wire logic       rsp_last
);

   // A run closes with a carriage return and only there
   a_last_is_cr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> (rsp_character == slcan_pkg::CHAR_CR))
      else $error("last beat is not a carriage return");

   a_cr_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_character != slcan_pkg::CHAR_CR))
      else $error("carriage return inside a run");

   // A run that follows straight on opens with a header letter
   a_next_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> (!rsp_strobe
         || (rsp_character == slcan_pkg::CHAR_EXT)
         || (rsp_character == slcan_pkg::CHAR_STD)))
      else $error("run does not open with a header letter");

   // A run after a gap opens with a header letter
   a_first_head: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> ((rsp_character == slcan_pkg::CHAR_EXT)
         || (rsp_character == slcan_pkg::CHAR_STD)))
      else $error("stream starts mid-run");

   // Nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("beat right after reset");

endmodule

bind slcan_frame_encoder_top slcan_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_strobe    (rsp_strobe),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

`default_nettype wire
